// ===== rtl/blca_pkg.sv =====
// Shared types, sizes and codes for the binary lifting common ancestor engine.
package blca_pkg;

   localparam int NODES    = 1024;
   localparam int LEVELS   = 10;
   localparam int NODE_W   = $clog2(NODES);
   localparam int LVL_W    = $clog2(LEVELS + 1);
   localparam int ENTRY_W  = NODE_W + 1;
   localparam int CNT_W    = 11;
   localparam int JT_DEPTH = (LEVELS + 1) * NODES;
   localparam int JT_AW    = $clog2(JT_DEPTH);

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [LVL_W-1:0]   lvl_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [JT_AW-1:0]   jt_addr_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0] op;
      node_type   node_a;
      node_type   node_b;
      logic       has_parent;
   } req_type;

   typedef struct packed {
      node_type common_ancestor;
      logic     has_common;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_LOAD,
      CMD_B1_START,
      CMD_B1_READ,
      CMD_B1_PARENT,
      CMD_B1_DEPTH,
      CMD_B2_START,
      CMD_B2_READ,
      CMD_B2_PARENT,
      CMD_B2_WRITE,
      CMD_Q_CHECK,
      CMD_Q_DEPTH,
      CMD_Q_READ,
      CMD_Q_ENTRY,
      CMD_Q_LIFT,
      CMD_Q_MEET,
      CMD_Q_READ2,
      CMD_Q_JOINT,
      CMD_Q_RESULT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic j_zero;
      logic j_last;
      logic lvl_zero;
      logic lvl_top;
      logic range_ok;
      logic lift_stop;
      logic uv_equal;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_B1_START,
      S_B1_READ,
      S_B1_PARENT,
      S_B1_DEPTH,
      S_B2_START,
      S_B2_READ,
      S_B2_PARENT,
      S_B2_WRITE,
      S_Q_CHECK,
      S_Q_DEPTH,
      S_Q_READ,
      S_Q_ENTRY,
      S_Q_LIFT,
      S_Q_MEET,
      S_Q_READ2,
      S_Q_JOINT,
      S_Q_RESULT,
      S_Q_OUT
   } ctrl_state_type;

endpackage

// ===== rtl/blca_dp.sv =====
// Datapath: jump table and depth memories, climb registers and comparators.
module blca_dp (
   input  logic                   clock,
   input  blca_pkg::req_type       req_data,
   input  blca_pkg::entry_type     active_cnt,
   input  blca_pkg::ctrl_cmd_type  cmd,
   output blca_pkg::dp_status_type status,
   output blca_pkg::entry_type     result
);
   import blca_pkg::*;

   // entry code: 0 is "no node", k+1 is node k
   function automatic jt_addr_type jt_addr(input lvl_type l, input node_type n);
      jt_addr = JT_AW'(l) * JT_AW'(NODES) + JT_AW'(n);
   endfunction

   node_type  a_ff, a_in, b_ff, b_in, j_ff, j_in, u_ff, u_in, v_ff, v_in;
   logic      hp_ff, hp_in;
   lvl_type   lvl_ff, lvl_in;
   entry_type e_ff, e_in, dv_ff, dv_in, res_ff, res_in;

   entry_type   jt_mem [JT_DEPTH];
   logic        jt_we;
   jt_addr_type jt_waddr, jt_raddr_a, jt_raddr_b;
   entry_type   jt_wdata, jt_rd_a_ff, jt_rd_b_ff;

   entry_type dep_mem [NODES];
   logic      dep_we;
   node_type  dep_waddr, dep_raddr_a, dep_raddr_b;
   entry_type dep_wdata, dep_rd_a_ff, dep_rd_b_ff;

   lvl_type   cl;
   node_type  rd_a_node, rd_b_node, u_lift, u_joint, v_joint;
   entry_type par, san;
   logic      par_bad, take, joint_step;

   assign cl        = (lvl_ff == '0) ? '0 : lvl_ff - LVL_W'(1);
   assign rd_a_node = NODE_W'(jt_rd_a_ff - ENTRY_W'(1));
   assign rd_b_node = NODE_W'(jt_rd_b_ff - ENTRY_W'(1));

   // a parent must sit above its child and inside the active range
   assign par     = jt_rd_a_ff - ENTRY_W'(1);
   assign par_bad = (jt_rd_a_ff != '0) &&
                    ((par <= ENTRY_W'(j_ff)) || (par >= active_cnt));
   assign san     = par_bad ? '0 : jt_rd_a_ff;

   assign take   = (e_ff != '0) && (dep_rd_a_ff >= dv_ff);
   assign u_lift = take ? NODE_W'(e_ff - ENTRY_W'(1)) : u_ff;

   // joint step skipped when the entries meet or either side has run out
   assign joint_step = (jt_rd_a_ff != jt_rd_b_ff) && (jt_rd_a_ff != '0) &&
                       (jt_rd_b_ff != '0);
   assign u_joint    = joint_step ? rd_a_node : u_ff;
   assign v_joint    = joint_step ? rd_b_node : v_ff;

   assign status.cnt_zero  = (active_cnt == '0);
   assign status.j_zero    = (j_ff == '0);
   assign status.j_last    = (ENTRY_W'(j_ff) == active_cnt - ENTRY_W'(1));
   assign status.lvl_zero  = (lvl_ff == '0);
   assign status.lvl_top   = (lvl_ff == LVL_W'(LEVELS));
   assign status.range_ok  = (ENTRY_W'(a_ff) < active_cnt) &&
                             (ENTRY_W'(b_ff) < active_cnt);
   assign status.lift_stop = take && (dep_rd_a_ff == dv_ff);
   assign status.uv_equal  = (u_ff == v_ff);

   assign result = res_ff;

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      hp_in       = hp_ff;
      j_in        = j_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      lvl_in      = lvl_ff;
      e_in        = e_ff;
      dv_in       = dv_ff;
      res_in      = res_ff;
      jt_we       = 1'b0;
      jt_waddr    = '0;
      jt_wdata    = '0;
      jt_raddr_a  = '0;
      jt_raddr_b  = '0;
      dep_we      = 1'b0;
      dep_waddr   = '0;
      dep_wdata   = '0;
      dep_raddr_a = '0;
      dep_raddr_b = '0;
      unique case (cmd.op)
         CMD_NONE: begin
         end
         CMD_LATCH: begin
            a_in  = req_data.node_a;
            b_in  = req_data.node_b;
            hp_in = req_data.has_parent;
         end
         CMD_LOAD: begin
            jt_we    = 1'b1;
            jt_waddr = jt_addr('0, a_ff);
            jt_wdata = hp_ff ? ENTRY_W'(b_ff) + ENTRY_W'(1) : '0;
         end
         CMD_B1_START: begin
            j_in = NODE_W'(active_cnt - ENTRY_W'(1));
         end
         CMD_B1_READ: begin
            jt_raddr_a = jt_addr('0, j_ff);
         end
         CMD_B1_PARENT: begin
            e_in        = san;
            jt_we       = 1'b1;
            jt_waddr    = jt_addr('0, j_ff);
            jt_wdata    = san;
            dep_raddr_a = NODE_W'(san - ENTRY_W'(1));
         end
         CMD_B1_DEPTH: begin
            dep_we    = 1'b1;
            dep_waddr = j_ff;
            dep_wdata = (e_ff == '0) ? '0 : dep_rd_a_ff + ENTRY_W'(1);
            j_in      = j_ff - NODE_W'(1);
         end
         CMD_B2_START: begin
            lvl_in = LVL_W'(1);
            j_in   = '0;
         end
         CMD_B2_READ: begin
            jt_raddr_a = jt_addr(lvl_ff - LVL_W'(1), j_ff);
         end
         CMD_B2_PARENT: begin
            e_in       = jt_rd_a_ff;
            jt_raddr_a = jt_addr(lvl_ff - LVL_W'(1), rd_a_node);
         end
         CMD_B2_WRITE: begin
            jt_we    = 1'b1;
            jt_waddr = jt_addr(lvl_ff, j_ff);
            jt_wdata = (e_ff == '0) ? '0 : jt_rd_a_ff;
            if (status.j_last) begin
               j_in   = '0;
               lvl_in = lvl_ff + LVL_W'(1);
            end else begin
               j_in = j_ff + NODE_W'(1);
            end
         end
         CMD_Q_CHECK: begin
            res_in      = '0;
            dep_raddr_a = a_ff;
            dep_raddr_b = b_ff;
         end
         CMD_Q_DEPTH: begin
            if (dep_rd_a_ff < dep_rd_b_ff) begin
               u_in  = b_ff;
               v_in  = a_ff;
               dv_in = dep_rd_a_ff;
            end else begin
               u_in  = a_ff;
               v_in  = b_ff;
               dv_in = dep_rd_b_ff;
            end
            lvl_in = LVL_W'(LEVELS);
         end
         CMD_Q_READ: begin
            jt_raddr_a = jt_addr(lvl_ff, u_ff);
         end
         CMD_Q_ENTRY: begin
            e_in        = jt_rd_a_ff;
            dep_raddr_a = rd_a_node;
         end
         CMD_Q_LIFT: begin
            u_in       = u_lift;
            lvl_in     = cl;
            jt_raddr_a = jt_addr(cl, u_lift);
         end
         CMD_Q_MEET: begin
            res_in = ENTRY_W'(u_ff) + ENTRY_W'(1);
            lvl_in = LVL_W'(LEVELS);
         end
         CMD_Q_READ2: begin
            jt_raddr_a = jt_addr(lvl_ff, u_ff);
            jt_raddr_b = jt_addr(lvl_ff, v_ff);
         end
         CMD_Q_JOINT: begin
            u_in       = u_joint;
            v_in       = v_joint;
            lvl_in     = cl;
            jt_raddr_a = jt_addr(cl, u_joint);
            jt_raddr_b = jt_addr(cl, v_joint);
         end
         CMD_Q_RESULT: begin
            res_in = jt_rd_a_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      hp_ff  <= hp_in;
      j_ff   <= j_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      lvl_ff <= lvl_in;
      e_ff   <= e_in;
      dv_ff  <= dv_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (jt_we) begin
         jt_mem[jt_waddr] <= jt_wdata;
      end
      jt_rd_a_ff <= jt_mem[jt_raddr_a];
      jt_rd_b_ff <= jt_mem[jt_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_waddr] <= dep_wdata;
      end
      dep_rd_a_ff <= dep_mem[dep_raddr_a];
      dep_rd_b_ff <= dep_mem[dep_raddr_b];
   end

endmodule

// ===== rtl/blca_ctrl.sv =====
// Controller: sequences load, build and query steps of the datapath.
module blca_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_op,
   output logic                    req_stall,
   input  blca_pkg::dp_status_type status,
   input  logic                    rsp_busy,
   output blca_pkg::ctrl_cmd_type  cmd,
   output logic                    rsp_load
);
   import blca_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = CMD_NONE;
      rsp_load  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = CMD_LATCH;
               unique case (req_op)
                  OP_LOAD:  state_in = S_LOAD;
                  OP_BUILD: state_in = S_B1_START;
                  OP_QUERY: state_in = S_Q_CHECK;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.op   = CMD_LOAD;
            state_in = S_IDLE;
         end
         S_B1_START: begin
            cmd.op   = CMD_B1_START;
            state_in = status.cnt_zero ? S_IDLE : S_B1_READ;
         end
         S_B1_READ: begin
            cmd.op   = CMD_B1_READ;
            state_in = S_B1_PARENT;
         end
         S_B1_PARENT: begin
            cmd.op   = CMD_B1_PARENT;
            state_in = S_B1_DEPTH;
         end
         S_B1_DEPTH: begin
            cmd.op   = CMD_B1_DEPTH;
            state_in = status.j_zero ? S_B2_START : S_B1_READ;
         end
         S_B2_START: begin
            cmd.op   = CMD_B2_START;
            state_in = S_B2_READ;
         end
         S_B2_READ: begin
            cmd.op   = CMD_B2_READ;
            state_in = S_B2_PARENT;
         end
         S_B2_PARENT: begin
            cmd.op   = CMD_B2_PARENT;
            state_in = S_B2_WRITE;
         end
         S_B2_WRITE: begin
            cmd.op   = CMD_B2_WRITE;
            state_in = (status.j_last && status.lvl_top) ? S_IDLE : S_B2_READ;
         end
         S_Q_CHECK: begin
            cmd.op   = CMD_Q_CHECK;
            state_in = status.range_ok ? S_Q_DEPTH : S_Q_OUT;
         end
         S_Q_DEPTH: begin
            cmd.op   = CMD_Q_DEPTH;
            state_in = S_Q_READ;
         end
         S_Q_READ: begin
            cmd.op   = CMD_Q_READ;
            state_in = S_Q_ENTRY;
         end
         S_Q_ENTRY: begin
            cmd.op   = CMD_Q_ENTRY;
            state_in = S_Q_LIFT;
         end
         S_Q_LIFT: begin
            cmd.op   = CMD_Q_LIFT;
            state_in = (status.lift_stop || status.lvl_zero) ? S_Q_MEET : S_Q_ENTRY;
         end
         S_Q_MEET: begin
            cmd.op   = CMD_Q_MEET;
            state_in = status.uv_equal ? S_Q_OUT : S_Q_READ2;
         end
         S_Q_READ2: begin
            cmd.op   = CMD_Q_READ2;
            state_in = S_Q_JOINT;
         end
         S_Q_JOINT: begin
            cmd.op   = CMD_Q_JOINT;
            state_in = status.lvl_zero ? S_Q_RESULT : S_Q_JOINT;
         end
         S_Q_RESULT: begin
            cmd.op   = CMD_Q_RESULT;
            state_in = S_Q_OUT;
         end
         S_Q_OUT: begin
            if (!rsp_busy) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

endmodule

// ===== rtl/binary_lifting_lca_engine.sv =====
// Top level: lowest common ancestor engine with node count register and response register.
//
// Lowest common ancestor engine over a rooted forest using binary lifting. A load
// request stores one node's parent (or marks it a root) in level 0 of the jump
// table. A build request sanitizes every parent (it must sit above its child and
// inside the node count), computes depths in one descending pass, then fills
// levels 1..LEVELS of the table. A query request returns the lowest common
// ancestor of two nodes, with has_common clear when they share none or either
// node is outside the count. Only queries produce a response. The controller
// works on one request at a time and stalls new requests until it is idle again.
// A query lifts the deeper node to the depth of the other in a loop that can stop
// early; if the two nodes still differ, it then climbs both together level by
// level. A query with a node out of range skips both steps. Neither memory is
// cleared at reset: a query before the first build, or a build over nodes that
// were never loaded, returns undefined data. The response register holds a
// finished result while a new request is taken; a later query waits in its last
// step until that result has been taken. The user must see that node_count is
// written only while the engine is idle; the block itself does not enforce this.
module binary_lifting_lca_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  blca_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output blca_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  blca_pkg::cnt_type csr_data
);
   import blca_pkg::*;

   cnt_type       node_count_ff, node_count_in;
   entry_type     active_cnt;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          rsp_busy, rsp_load;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   entry_type     result;

   // config register is always writable; software keeps writes to idle periods
   assign csr_ready     = 1'b1;
   assign node_count_in = (csr_valid && csr_ready) ? csr_data : node_count_ff;

   // counts above the table size clamp to the table size
   assign active_cnt = (node_count_ff > CNT_W'(NODES)) ? ENTRY_W'(NODES)
                                                      : ENTRY_W'(node_count_ff);

   // response register: holds one result while the next request runs
   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.has_common      = (result != '0);
         rsp_data_in.common_ancestor = (result != '0) ? NODE_W'(result - ENTRY_W'(1))
                                                      : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(NODES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   blca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .rsp_busy  (rsp_busy),
      .cmd       (cmd),
      .rsp_load  (rsp_load)
   );

   blca_dp u_dp (
      .clock      (clock),
      .req_data   (req_data),
      .active_cnt (active_cnt),
      .cmd        (cmd),
      .status     (status),
      .result     (result)
   );

endmodule
